FILE: rtl/core/dll_pkg.sv
// Shared field widths and command codes for the doubly linked list manager.
package dll_pkg;

  localparam int CMD_W   = 3;
  localparam int NODE_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET_NEXT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET_PREV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_NTH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

endpackage

FILE: rtl/core/dll_req_if.sv
// Command channel: valid/ready handshake carrying one list command.
interface dll_req_if;
  import dll_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NODE_W-1:0] item_node;
  logic              item_present;
  logic [NODE_W-1:0] target_node;
  logic              target_present;
  logic [NODE_W-1:0] nth_index;

  modport source (
    output valid, command, item_node, item_present, target_node, target_present, nth_index,
    input  ready
  );

  modport sink (
    input  valid, command, item_node, item_present, target_node, target_present, nth_index,
    output ready
  );

endinterface

FILE: rtl/core/dll_rsp_if.sv
// Result channel: valid/ready handshake carrying one command result.
interface dll_rsp_if;
  import dll_pkg::*;

  logic               valid;
  logic               ready;
  logic [NODE_W-1:0]  result_node;
  logic               result_valid;
  logic [COUNT_W-1:0] list_count;

  modport source (
    output valid, result_node, result_valid, list_count,
    input  ready
  );

  modport sink (
    input  valid, result_node, result_valid, list_count,
    output ready
  );

endinterface

FILE: rtl/core/dll_link_ram.sv
// Link table: single write port, single read port, registered read data.
module dll_link_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/doubly_linked_list_manager.sv
// Doubly linked list manager: one list over a pool of node slots.
//
// Commands arrive on req (valid/ready); one result per command leaves on rsp.
// A transfer happens on a rising edge with valid and ready both high.
// Predecessor and successor links sit in two RAMs with registered read data;
// head, tail and count are registers. The sequencer takes one command at a
// time. Steps per command, from accept to the next possible accept:
//   insert, remove           read links, write in S_WR1 and S_WR2, result
//   get next/prev with node  one link read, result
//   get next/prev, no node; clear and unused codes: result only
//   get nth                  one link read per link followed, result
// The result is held in an output register; a stalled receiver holds it and
// the sequencer waits in its result step until the register frees, so a new
// command may be accepted while an earlier result is still waiting.
// Reset (rst, synchronous) empties the list: head and tail take the none
// marker and the count goes to zero. The link RAMs are not cleared; reading a
// link of a slot never inserted gives an unspecified node.
module doubly_linked_list_manager #(
  parameter int NODE_SLOTS = 256
) (
  input logic clk,
  input logic rst,
  dll_req_if.sink   req,
  dll_rsp_if.source rsp
);
  import dll_pkg::*;

  localparam int IW = $clog2(NODE_SLOTS);
  localparam int LW = $clog2(NODE_SLOTS + 1);
  localparam logic [LW-1:0] NONE = LW'(NODE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_WR1, S_WR2, S_RD_NEXT, S_RD_PREV, S_WALK, S_WALK_RD, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_APPEND, OP_PREPEND, OP_BEFORE, OP_REMOVE
  } op_t;

  function automatic logic pool_link(input logic [LW-1:0] v);
    return 32'(v) < NODE_SLOTS;
  endfunction

  function automatic logic pool_node(input logic [NODE_W-1:0] v);
    return 32'(v) < NODE_SLOTS;
  endfunction

  state_t             state;
  op_t                op;
  logic [LW-1:0]      n;
  logic [LW-1:0]      t;
  logic [LW-1:0]      p;
  logic [LW-1:0]      head;
  logic [LW-1:0]      tail;
  logic [COUNT_W-1:0] count;
  logic [LW-1:0]      walk;
  logic [NODE_W-1:0]  left;
  logic [LW-1:0]      found;
  logic               out_valid;
  logic [NODE_W-1:0]  out_node;
  logic               out_flag;
  logic [COUNT_W-1:0] out_count;

  logic [31:0]   item_w, tgt_w, found_w;
  logic [LW-1:0] item_lw, tgt_lw;

  logic          nx_we, pv_we;
  logic [IW-1:0] nx_waddr, pv_waddr, nx_raddr, pv_raddr;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  assign item_w  = {{(32-NODE_W){1'b0}}, req.item_node};
  assign tgt_w   = {{(32-NODE_W){1'b0}}, req.target_node};
  assign item_lw = item_w[LW-1:0];
  assign tgt_lw  = tgt_w[LW-1:0];
  assign found_w = 32'(found);

  assign req.ready        = (state == S_IDLE) && !rst;
  assign rsp.valid        = out_valid;
  assign rsp.result_node  = out_node;
  assign rsp.result_valid = out_flag;
  assign rsp.list_count   = out_count;

  dll_link_ram #(.DEPTH(NODE_SLOTS), .AW(IW), .DW(LW)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  dll_link_ram #(.DEPTH(NODE_SLOTS), .AW(IW), .DW(LW)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  // link RAM port control
  always_comb begin
    nx_raddr = item_w[IW-1:0];
    pv_raddr = item_w[IW-1:0];
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_waddr = n[IW-1:0];
    pv_waddr = n[IW-1:0];
    nx_wdata = NONE;
    pv_wdata = NONE;
    unique case (state)
      S_IDLE: begin
        if (req.command == CMD_INSERT) begin
          pv_raddr = tgt_w[IW-1:0];
        end
      end
      S_WALK: begin
        nx_raddr = walk[IW-1:0];
      end
      S_WR1: begin
        unique case (op)
          OP_APPEND: begin
            pv_we    = 1'b1;
            pv_wdata = (head == NONE) ? NONE : tail;
            nx_we    = 1'b1;
          end
          OP_PREPEND: begin
            pv_we    = 1'b1;
            nx_we    = 1'b1;
            nx_wdata = head;
          end
          OP_BEFORE: begin
            pv_we    = 1'b1;
            pv_wdata = pv_rdata;
            nx_we    = 1'b1;
            nx_wdata = t;
          end
          OP_REMOVE: begin
            nx_we    = pool_link(pv_rdata);
            nx_waddr = pv_rdata[IW-1:0];
            nx_wdata = nx_rdata;
            pv_we    = pool_link(nx_rdata);
            pv_waddr = nx_rdata[IW-1:0];
            pv_wdata = pv_rdata;
          end
        endcase
      end
      S_WR2: begin
        unique case (op)
          OP_APPEND: begin
            nx_we    = (head != NONE) && pool_link(tail);
            nx_waddr = tail[IW-1:0];
            nx_wdata = n;
          end
          OP_PREPEND: begin
            pv_we    = pool_link(head);
            pv_waddr = head[IW-1:0];
            pv_wdata = n;
          end
          OP_BEFORE: begin
            nx_we    = pool_link(p);
            nx_waddr = p[IW-1:0];
            nx_wdata = n;
            pv_we    = 1'b1;
            pv_waddr = t[IW-1:0];
            pv_wdata = n;
          end
          OP_REMOVE: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
          end
        endcase
      end
      S_RD_NEXT, S_RD_PREV, S_WALK_RD, S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NONE;
      tail      <= NONE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            n     <= item_lw;
            t     <= tgt_lw;
            left  <= req.nth_index;
            found <= NONE;
            state <= S_DONE;
            unique case (req.command)
              CMD_INSERT: begin
                if (req.item_present && pool_node(req.item_node)) begin
                  if (!req.target_present) begin
                    op    <= OP_APPEND;
                    state <= S_WR1;
                  end else if (pool_node(req.target_node)) begin
                    op    <= (tgt_lw == head) ? OP_PREPEND : OP_BEFORE;
                    state <= S_WR1;
                  end
                end
              end
              CMD_REMOVE: begin
                if (req.item_present && pool_node(req.item_node)) begin
                  op    <= OP_REMOVE;
                  state <= S_WR1;
                end
              end
              CMD_GET_NEXT: begin
                if (!req.item_present) begin
                  found <= head;
                end else if (pool_node(req.item_node)) begin
                  state <= S_RD_NEXT;
                end
              end
              CMD_GET_PREV: begin
                if (!req.item_present) begin
                  found <= tail;
                end else if (pool_node(req.item_node)) begin
                  state <= S_RD_PREV;
                end
              end
              CMD_GET_NTH: begin
                walk  <= head;
                state <= S_WALK;
              end
              CMD_CLEAR: begin
                head  <= NONE;
                tail  <= NONE;
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_WR1: begin
          p <= pv_rdata;
          if (op == OP_REMOVE) begin
            if (pv_rdata == NONE) begin
              head <= nx_rdata;
            end
            if (nx_rdata == NONE) begin
              tail <= pv_rdata;
            end
          end
          state <= S_WR2;
        end
        S_WR2: begin
          unique case (op)
            OP_APPEND: begin
              if (head == NONE) begin
                head <= n;
              end
              tail <= n;
            end
            OP_PREPEND: begin
              head <= n;
            end
            OP_BEFORE, OP_REMOVE: begin
            end
          endcase
          if (op == OP_REMOVE) begin
            if (count != '0) begin
              count <= count - 1'b1;
            end
          end else if (count != COUNT_MAX) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_RD_NEXT: begin
          found <= nx_rdata;
          state <= S_DONE;
        end
        S_RD_PREV: begin
          found <= pv_rdata;
          state <= S_DONE;
        end
        S_WALK: begin
          if (left == '0 || !pool_link(walk)) begin
            found <= walk;
            state <= S_DONE;
          end else begin
            left  <= left - 1'b1;
            state <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          walk  <= nx_rdata;
          state <= S_WALK;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_flag  <= pool_link(found);
            out_node  <= pool_link(found) ? found_w[NODE_W-1:0] : '0;
            out_count <= count;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
